// ===== rtl/tkns_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the top-k neighbor select block.
package tkns_pkg;

  localparam int DEF_MAX_KEEP    = 16;
  localparam int DEF_VERTEX_BITS = 20;
  localparam int DEF_SCORE_BITS  = 16;
  localparam int KEEP_CFG_BITS   = 5;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_REPLACE,
    CELL_SHIFT
  } cell_mode_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } tkns_state_t;

endpackage

// ===== rtl/top_k_neighbor_select.sv =====
`timescale 1ns / 1ps
// Top level of the streaming top-k neighbor select block.
//
// Input channel (in_valid / in_stall) carries the neighbor words of each source
// vertex run: source id, neighbor id, shared count score, tie coin and last flag.
// Kept entries sit in a chain of MAX_KEEP cells held sorted by ascending
// score, ties in insertion order; cell 0 is always the entry to replace.
// Each accepted neighbor word updates the chain: all cells compare against
// the new score in parallel and insert, replace or hold in that same cycle.
// On the word marked last, the block stalls its input and drains the chain
// through cell 0 into the output register, one edge per cycle while the
// output is not stalled. The drain state is registered when the last word
// is taken; each edge then passes through the output register.
// The output channel (out_valid / out_stall) holds its word while stalled;
// the drain then pauses with it. The cfg port writes keep_count (k) and is
// always ready; write it only while the block is idle.
// Synchronous reset empties the chain, drops any pending output and sets
// k to 1.
module top_k_neighbor_select #(
  parameter int MAX_KEEP    = tkns_pkg::DEF_MAX_KEEP,
  parameter int VERTEX_BITS = tkns_pkg::DEF_VERTEX_BITS,
  parameter int SCORE_BITS  = tkns_pkg::DEF_SCORE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [VERTEX_BITS-1:0]              in_source_vertex,
  input  logic [VERTEX_BITS-1:0]              in_neighbor_vertex,
  input  logic [SCORE_BITS-1:0]               in_shared_count,
  input  logic                                in_tie_coin,
  input  logic                                in_last_neighbor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [VERTEX_BITS-1:0]              out_edge_from,
  output logic [VERTEX_BITS-1:0]              out_edge_to,
  output logic                                out_last_edge,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tkns_pkg::KEEP_CFG_BITS-1:0]  cfg_keep_count
);

  localparam int FW = $clog2(MAX_KEEP + 1);
  localparam int CW = (FW > tkns_pkg::KEEP_CFG_BITS) ? FW : tkns_pkg::KEEP_CFG_BITS;

  tkns_pkg::tkns_state_t state_r, state_nxt;
  logic [FW-1:0]                       fill_r, fill_nxt;
  logic [tkns_pkg::KEEP_CFG_BITS-1:0]  keep_count_r, keep_count_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [VERTEX_BITS-1:0]              src_r, src_nxt;
  logic [VERTEX_BITS-1:0]              edge_from_r, edge_from_nxt;
  logic [VERTEX_BITS-1:0]              edge_to_r, edge_to_nxt;
  logic                                last_edge_r, last_edge_nxt;

  logic                   in_accept;
  logic                   load;
  logic                   fill_lt_k;
  logic                   do_replace;
  logic [CW-1:0]          keep_ext;
  logic [CW-1:0]          k_eff;
  tkns_pkg::cell_mode_t   mode;

  logic [MAX_KEEP-1:0]    cell_valid;
  logic [MAX_KEEP-1:0]    cell_gt;
  logic [MAX_KEEP-1:0]    cell_le;
  logic [SCORE_BITS-1:0]  cell_score [MAX_KEEP];
  logic [VERTEX_BITS-1:0] cell_nbr   [MAX_KEEP];

  // effective k, saturated into 1..MAX_KEEP
  always_comb begin
    keep_ext = CW'(keep_count_r);
    if (keep_ext == '0) begin
      k_eff = CW'(1);
    end else if (keep_ext > CW'(MAX_KEEP)) begin
      k_eff = CW'(MAX_KEEP);
    end else begin
      k_eff = keep_ext;
    end
  end

  assign fill_lt_k  = CW'(fill_r) < k_eff;
  assign do_replace = (in_shared_count > cell_score[0]) ||
                      ((in_shared_count == cell_score[0]) && in_tie_coin);

  // handshake and cell mode decode
  always_comb begin
    in_stall  = (state_r == tkns_pkg::ST_DRAIN);
    load      = (state_r == tkns_pkg::ST_DRAIN) && (!out_valid_r || !out_stall);
    in_accept = in_valid && !in_stall;
    mode      = tkns_pkg::CELL_HOLD;
    if (in_accept) begin
      if (fill_lt_k) begin
        mode = tkns_pkg::CELL_APPEND;
      end else if (do_replace) begin
        mode = tkns_pkg::CELL_REPLACE;
      end
    end else if (load) begin
      mode = tkns_pkg::CELL_SHIFT;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkns_pkg::ST_COLLECT: begin
        if (in_accept && in_last_neighbor) begin
          state_nxt = tkns_pkg::ST_DRAIN;
        end
      end
      tkns_pkg::ST_DRAIN: begin
        if (load && (fill_r == FW'(1))) begin
          state_nxt = tkns_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = tkns_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    fill_nxt       = fill_r;
    keep_count_nxt = keep_count_r;
    src_nxt        = src_r;
    out_valid_nxt  = out_valid_r && out_stall;
    edge_from_nxt  = edge_from_r;
    edge_to_nxt    = edge_to_r;
    last_edge_nxt  = last_edge_r;
    if (mode == tkns_pkg::CELL_APPEND) begin
      fill_nxt = fill_r + FW'(1);
    end else if (mode == tkns_pkg::CELL_SHIFT) begin
      fill_nxt = fill_r - FW'(1);
    end
    if (in_accept) begin
      src_nxt = in_source_vertex;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      edge_from_nxt = src_r;
      edge_to_nxt   = cell_nbr[0];
      last_edge_nxt = (fill_r == FW'(1));
    end
    if (cfg_valid) begin
      keep_count_nxt = cfg_keep_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tkns_pkg::ST_COLLECT;
      fill_r       <= '0;
      keep_count_r <= tkns_pkg::KEEP_CFG_BITS'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      keep_count_r <= keep_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    edge_from_r <= edge_from_nxt;
    edge_to_r   <= edge_to_nxt;
    last_edge_r <= last_edge_nxt;
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                   p_gt, p_le, n_le;
    logic [SCORE_BITS-1:0]  p_score, n_score;
    logic [VERTEX_BITS-1:0] p_nbr, n_nbr;

    assign cell_valid[i] = FW'(i) < fill_r;

    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_le    = 1'b1;
      assign p_score = cell_score[i];
      assign p_nbr   = cell_nbr[i];
    end else begin : g_body
      assign p_gt    = cell_gt[i-1];
      assign p_le    = cell_le[i-1];
      assign p_score = cell_score[i-1];
      assign p_nbr   = cell_nbr[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign n_le    = 1'b0;
      assign n_score = cell_score[i];
      assign n_nbr   = cell_nbr[i];
    end else begin : g_link
      assign n_le    = cell_le[i+1];
      assign n_score = cell_score[i+1];
      assign n_nbr   = cell_nbr[i+1];
    end

    tkns_cell #(
      .VERTEX_BITS(VERTEX_BITS),
      .SCORE_BITS (SCORE_BITS)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .valid     (cell_valid[i]),
      .new_score (in_shared_count),
      .new_nbr   (in_neighbor_vertex),
      .prev_gt   (p_gt),
      .prev_le   (p_le),
      .prev_score(p_score),
      .prev_nbr  (p_nbr),
      .next_le   (n_le),
      .next_score(n_score),
      .next_nbr  (n_nbr),
      .score     (cell_score[i]),
      .nbr       (cell_nbr[i]),
      .gt        (cell_gt[i]),
      .le        (cell_le[i])
    );
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_edge_from = edge_from_r;
  assign out_edge_to   = edge_to_r;
  assign out_last_edge = last_edge_r;

`ifndef ASSERT_OFF
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkns_pkg::ST_DRAIN) |-> (fill_r != '0))
    else $error("drain with empty chain");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(MAX_KEEP))
    else $error("fill count beyond chain length");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_neighbor) |=> (state_r == tkns_pkg::ST_DRAIN))
    else $error("last neighbor did not start drain");

  a_last_edge_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (fill_r == FW'(1))) |=> (out_valid_r && out_last_edge &&
    (fill_r == '0)))
    else $error("final edge not flagged or chain not empty");
`endif

endmodule

// ===== rtl/tkns_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted keep chain: holds one score and neighbor.
module tkns_cell #(
  parameter int VERTEX_BITS = tkns_pkg::DEF_VERTEX_BITS,
  parameter int SCORE_BITS  = tkns_pkg::DEF_SCORE_BITS
) (
  input  logic                   clk,
  input  tkns_pkg::cell_mode_t   mode,
  input  logic                   valid,
  input  logic [SCORE_BITS-1:0]  new_score,
  input  logic [VERTEX_BITS-1:0] new_nbr,
  input  logic                   prev_gt,
  input  logic                   prev_le,
  input  logic [SCORE_BITS-1:0]  prev_score,
  input  logic [VERTEX_BITS-1:0] prev_nbr,
  input  logic                   next_le,
  input  logic [SCORE_BITS-1:0]  next_score,
  input  logic [VERTEX_BITS-1:0] next_nbr,
  output logic [SCORE_BITS-1:0]  score,
  output logic [VERTEX_BITS-1:0] nbr,
  output logic                   gt,
  output logic                   le
);

  logic [SCORE_BITS-1:0]  score_r, score_nxt;
  logic [VERTEX_BITS-1:0] nbr_r, nbr_nxt;

  assign score = score_r;
  assign nbr   = nbr_r;
  assign gt    = valid && (score_r > new_score);
  assign le    = valid && !(score_r > new_score);

  always_comb begin
    score_nxt = score_r;
    nbr_nxt   = nbr_r;
    case (mode)
      tkns_pkg::CELL_APPEND: begin
        if (prev_gt) begin
          score_nxt = prev_score;
          nbr_nxt   = prev_nbr;
        end else if ((gt || !valid) && prev_le) begin
          score_nxt = new_score;
          nbr_nxt   = new_nbr;
        end
      end
      tkns_pkg::CELL_REPLACE: begin
        if (next_le) begin
          score_nxt = next_score;
          nbr_nxt   = next_nbr;
        end else if (le) begin
          score_nxt = new_score;
          nbr_nxt   = new_nbr;
        end
      end
      tkns_pkg::CELL_SHIFT: begin
        score_nxt = next_score;
        nbr_nxt   = next_nbr;
      end
      default: begin
        score_nxt = score_r;
        nbr_nxt   = nbr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    nbr_r   <= nbr_nxt;
  end

endmodule
